// ===== sv/dssm_pkg.sv =====
// Package for the dual stack shared memory block.
// Holds the mode and status codes, the default depth and the
// controller/datapath command and status structs. No dependencies.
package dssm_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH1 = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH2 = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP1  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP2  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP1 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP2 = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic take_in;   // input transaction this cycle
		logic take_cfg;  // base register write this cycle
		logic emit;      // move registered read data into the output register
	} dssm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_rd;  // current input item answers from memory
		logic more;      // read data in flight is not the final result
		logic out_free;  // output register can be loaded this cycle
	} dssm_stat_t;

endpackage

// ===== sv/dssm_ctrl.sv =====
// Controller for the dual stack shared memory block.
// Two-state machine sequencing memory reads for pops and dumps.
// Depends on dssm_pkg.
module dssm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  dssm_pkg::dssm_stat_t stat,
	output dssm_pkg::dssm_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		cfg_ready    = (state_q == ST_IDLE);
		// a pending config write wins over an input item
		in_ready     = (state_q == ST_IDLE) && !cfg_valid && stat.out_free;
		cmd.take_in  = in_valid && in_ready;
		cmd.take_cfg = cfg_valid && cfg_ready;
		cmd.emit     = (state_q == ST_READ) && stat.out_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take_in && stat.needs_rd) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				if (cmd.emit && !stat.more) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== sv/dssm_datapath.sv =====
// Datapath for the dual stack shared memory block: entry memory,
// stack pointers, read cursor and output register.
// Depends on dssm_pkg.
module dssm_datapath #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dssm_pkg::dssm_cmd_t                 cmd,
	output dssm_pkg::dssm_stat_t                stat,
	input  logic [dssm_pkg::MODE_W-1:0]         mode,
	input  logic signed [dssm_pkg::DATA_W-1:0]  push_value,
	input  logic                                base_mid_in,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [dssm_pkg::DATA_W-1:0]  data_out,
	output logic [dssm_pkg::STATUS_W-1:0]       status,
	output logic                                last
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] BASE_END = CW'(DEPTH);
	localparam logic [CW-1:0] BASE_MID = CW'(DEPTH / 2);

	logic [dssm_pkg::DATA_W-1:0] entry_mem_q [DEPTH];
	logic [dssm_pkg::DATA_W-1:0] rd_data_q;

	logic [CW-1:0] fill_q, low_q, base;
	logic          base_mid_q;
	logic [IW-1:0] cur_q;
	logic          last_q;
	logic          down_q;

	logic                                out_valid_q;
	logic signed [dssm_pkg::DATA_W-1:0]  data_out_q;
	logic [dssm_pkg::STATUS_W-1:0]       status_q;
	logic                                last_out_q;

	logic push_ok, pop1_ok, pop2_ok;
	logic needs_rd, imm_res, last_in, down_in;
	logic signed [dssm_pkg::DATA_W-1:0] imm_data;
	logic [dssm_pkg::STATUS_W-1:0]      imm_status;
	logic [IW-1:0] addr_in, nx_addr, rd_addr, wr_addr;
	logic          nx_last, rd_en, wr_en, ld_out;
	logic [CW-1:0] fill_m1, base_m1;

	always_comb begin
		base    = base_mid_q ? BASE_MID : BASE_END;
		fill_m1 = fill_q - 1'b1;
		base_m1 = base - 1'b1;
		push_ok = fill_q < low_q;
		pop1_ok = fill_q != '0;
		pop2_ok = low_q < base;

		needs_rd   = 1'b0;
		imm_res    = 1'b0;
		imm_data   = '0;
		imm_status = dssm_pkg::STAT_OK;
		addr_in    = '0;
		last_in    = 1'b1;
		down_in    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = fill_q[IW-1:0];
		case (mode)
			dssm_pkg::MODE_PUSH1, dssm_pkg::MODE_PUSH2: begin
				imm_res    = 1'b1;
				imm_status = push_ok ? dssm_pkg::STAT_OK : dssm_pkg::STAT_OVERFLOW;
				wr_en      = cmd.take_in && push_ok;
				if (mode == dssm_pkg::MODE_PUSH2) begin
					wr_addr = IW'(low_q - 1'b1);
				end
			end
			dssm_pkg::MODE_POP1: begin
				needs_rd = pop1_ok;
				addr_in  = fill_m1[IW-1:0];
			end
			dssm_pkg::MODE_POP2: begin
				needs_rd = pop2_ok;
				addr_in  = low_q[IW-1:0];
			end
			dssm_pkg::MODE_DUMP1: begin
				needs_rd = pop1_ok;
				addr_in  = '0;
				last_in  = (fill_q == CW'(1));
			end
			dssm_pkg::MODE_DUMP2: begin
				needs_rd = pop2_ok;
				addr_in  = base_m1[IW-1:0];
				last_in  = (low_q == base_m1);
				down_in  = 1'b1;
			end
			default: ;
		endcase
		// empty pops and dumps answer at once
		if (mode inside {dssm_pkg::MODE_POP1, dssm_pkg::MODE_POP2} && !needs_rd) begin
			imm_res    = 1'b1;
			imm_data   = -32'sd1;
			imm_status = dssm_pkg::STAT_UNDERFLOW;
		end
		if (mode inside {dssm_pkg::MODE_DUMP1, dssm_pkg::MODE_DUMP2} && !needs_rd) begin
			imm_res    = 1'b1;
			imm_status = dssm_pkg::STAT_EMPTY;
		end

		nx_addr = down_q ? cur_q - 1'b1 : cur_q + 1'b1;
		nx_last = down_q ? (CW'(nx_addr) == low_q) : (CW'(nx_addr) == fill_m1);

		rd_en   = (cmd.take_in && needs_rd) || (cmd.emit && !last_q);
		rd_addr = cmd.emit ? nx_addr : addr_in;
		ld_out  = (cmd.take_in && imm_res) || cmd.emit;

		stat.needs_rd = needs_rd;
		stat.more     = !last_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			low_q      <= BASE_END;
			base_mid_q <= 1'b0;
			cur_q      <= '0;
			last_q     <= 1'b1;
			down_q     <= 1'b0;
		end else begin
			if (cmd.take_cfg) begin
				base_mid_q <= base_mid_in;
				fill_q     <= '0;
				low_q      <= base_mid_in ? BASE_MID : BASE_END;
			end else if (cmd.take_in) begin
				case (mode)
					dssm_pkg::MODE_PUSH1: if (push_ok) fill_q <= fill_q + 1'b1;
					dssm_pkg::MODE_PUSH2: if (push_ok) low_q <= low_q - 1'b1;
					dssm_pkg::MODE_POP1:  if (pop1_ok) fill_q <= fill_m1;
					dssm_pkg::MODE_POP2:  if (pop2_ok) low_q <= low_q + 1'b1;
					default: ;
				endcase
			end
			if (cmd.take_in && needs_rd) begin
				cur_q  <= addr_in;
				last_q <= last_in;
				down_q <= down_in;
			end else if (cmd.emit && !last_q) begin
				cur_q  <= nx_addr;
				last_q <= nx_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_out_q <= rd_data_q;
			status_q   <= dssm_pkg::STAT_OK;
			last_out_q <= last_q;
		end else if (ld_out) begin
			data_out_q <= imm_data;
			status_q   <= imm_status;
			last_out_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign last      = last_out_q;

`ifndef SYNTH
	a_fill_below_low: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= low_q)
		else $error("stack 1 top crossed stack 2 top");
	a_low_within_base: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= base)
		else $error("stack 2 pointer above its base");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while stalled");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == dssm_pkg::STAT_EMPTY) |-> last_out_q)
		else $error("empty dump result not marked last");
`endif

endmodule

// ===== sv/dual_stack_shared_memory.sv =====
// Two stacks sharing one entry memory: top level.
// Instantiates dssm_ctrl and dssm_datapath; depends on dssm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, mode, push_value) takes one command per
//   transaction. Output channel (out_valid/out_ready, data_out, status, last)
//   returns one or more results; last marks the final one of a command.
//   Config channel (cfg_valid/cfg_ready, stack2_base_at_middle) sets stack 2's
//   base and empties both stacks; write it only while the block is idle.
// Timing:
//   Push and failed pop/dump: result in the output register in the cycle after
//   acceptance; a new command is taken every cycle while the receiver keeps up.
//   Successful pop: the memory read is registered, then the read data is moved
//   into the output register; next command taken once it has been loaded.
//   Dump of N entries: one entry per cycle while the receiver keeps up, paced
//   by the single memory read port. Modes 6 and 7 are taken with no result.
// Reset: both stacks empty, stack 2 base at memory end, output empty.
// Stall: a held output register blocks input and memory reads until taken.
module dual_stack_shared_memory #(
	parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dssm_pkg::MODE_W-1:0]         mode,
	input  logic signed [dssm_pkg::DATA_W-1:0]  push_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dssm_pkg::DATA_W-1:0]  data_out,
	output logic [dssm_pkg::STATUS_W-1:0]       status,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                stack2_base_at_middle
);

	dssm_pkg::dssm_cmd_t  cmd;
	dssm_pkg::dssm_stat_t stat;

	dssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dssm_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.push_value  (push_value),
		.base_mid_in (stack2_base_at_middle),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.data_out    (data_out),
		.status      (status),
		.last        (last)
	);

endmodule
